>>> sv/touch_sample_filter_top_defines.svh
// Assertion macros used by the touch sample filter checker
`ifndef TOUCH_SAMPLE_FILTER_TOP_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define TSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("touch_sample_filter: check failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define TSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("touch_sample_filter: check failed");

`endif

>>> sv/tsf_pkg.sv
// Types, constants and codes shared by the touch sample filter
`default_nettype none

package tsf_pkg;

  // Frame shape
  localparam int SAMPLE_GROUPS = 4;
  localparam int ADC_BITS      = 10;
  localparam int ADC_FULL      = 1 << ADC_BITS;

  // Fixed field widths
  localparam int OFS_W = 10;
  localparam int SCL_W = 16;
  localparam int LIM_W = 11;
  localparam int POS_W = 16;
  localparam int SCL_FRAC = 8;

  // Derived widths
  localparam int MM_W   = ADC_BITS + 1;
  localparam int AVG_W  = ADC_BITS + 1;
  localparam int WIDE_W = (AVG_W > LIM_W) ? AVG_W : LIM_W;
  localparam int SUM_W  = $clog2(2 * SAMPLE_GROUPS * ADC_FULL);
  localparam int GCNT_W = (SAMPLE_GROUPS > 1) ? $clog2(SAMPLE_GROUPS) : 1;

  // Divide by the number of values per frame through a reciprocal multiply
  localparam int DIVISOR   = 2 * SAMPLE_GROUPS;
  localparam int DIV_SHIFT = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_W   = SUM_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((longint'(1) << DIV_SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  // Shared multiplier operand widths
  localparam int MA_W   = (SUM_W > WIDE_W) ? SUM_W : WIDE_W;
  localparam int MB_W   = (RECIP_W > SCL_W) ? RECIP_W : SCL_W;
  localparam int PROD_W = MA_W + MB_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SPREAD_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SPREAD_LIMIT = 3'd6;

  // Register reset values
  localparam logic [OFS_W-1:0] X_OFFSET_RST       = 10'd100;
  localparam logic [OFS_W-1:0] Y_OFFSET_RST       = 10'd165;
  localparam logic [SCL_W-1:0] X_SCALE_RST        = 16'd256;
  localparam logic [SCL_W-1:0] Y_SCALE_RST        = 16'd256;
  localparam logic [LIM_W-1:0] LEVEL_LIMIT_RST    = 11'd910;
  localparam logic [LIM_W-1:0] X_SPREAD_LIMIT_RST = 11'd100;
  localparam logic [LIM_W-1:0] Y_SPREAD_LIMIT_RST = 11'd100;

  // Operation on the shared multiplier
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIV_X,
    OP_DIV_Y,
    OP_SCL_X,
    OP_SCL_Y
  } mul_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    acc;
    mul_op_e op;
    logic    load_out;
    logic    clear;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_group;
    logic out_free;
  } ctrl_status_t;

  // Channel payloads
  typedef struct packed {
    logic [ADC_BITS-1:0] x_forward;
    logic [ADC_BITS-1:0] y_forward;
    logic [ADC_BITS-1:0] x_reverse;
    logic [ADC_BITS-1:0] y_reverse;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic             touched;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/tsf_intf.sv
// Valid/ready channel interfaces for sample groups and results
`default_nettype none

interface tsf_in_if;
  logic              valid;
  logic              ready;
  tsf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsf_out_if;
  logic               valid;
  logic               ready;
  tsf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/tsf_ctrl.sv
// Frame sequencer for the touch sample filter
`default_nettype none

module tsf_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire tsf_pkg::ctrl_status_t status_i,
  output tsf_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_DIVX = 3'd1;
  localparam logic [2:0] S_DIVY = 3'd2;
  localparam logic [2:0] S_SCLX = 3'd3;
  localparam logic [2:0] S_SCLY = 3'd4;

  logic [2:0] state_q, state_d;

  // Step through accumulate, two divides, two scalings
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.acc      = 1'b0;
    cmd_o.op       = tsf_pkg::OP_NONE;
    cmd_o.load_out = 1'b0;
    cmd_o.clear    = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
        if (in_valid_i && status_i.last_group) begin
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd_o.op = tsf_pkg::OP_DIV_X;
        state_d  = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = tsf_pkg::OP_DIV_Y;
        state_d  = S_SCLX;
      end
      S_SCLX: begin
        cmd_o.op = tsf_pkg::OP_SCL_X;
        state_d  = S_SCLY;
      end
      S_SCLY: begin
        cmd_o.op = tsf_pkg::OP_SCL_Y;
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/tsf_datapath.sv
// Accumulators, shared multiplier, configuration and output register
`default_nettype none

module tsf_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [tsf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [tsf_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  wire tsf_pkg::in_item_t                in_data_i,
  input  wire tsf_pkg::ctrl_cmd_t               cmd_i,
  output tsf_pkg::ctrl_status_t                 status_o,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output tsf_pkg::out_item_t                    out_data_o
);

  localparam int MM_W   = tsf_pkg::MM_W;
  localparam int AVG_W  = tsf_pkg::AVG_W;
  localparam int WIDE_W = tsf_pkg::WIDE_W;
  localparam int SUM_W  = tsf_pkg::SUM_W;
  localparam int MA_W   = tsf_pkg::MA_W;
  localparam int MB_W   = tsf_pkg::MB_W;
  localparam int PROD_W = tsf_pkg::PROD_W;
  localparam int POS_W  = tsf_pkg::POS_W;
  localparam int FRAC   = tsf_pkg::SCL_FRAC;
  localparam int GCNT_W = tsf_pkg::GCNT_W;

  localparam logic [MM_W-1:0]   MM_FULL  = MM_W'(tsf_pkg::ADC_FULL);
  localparam logic [MM_W-1:0]   LOW_RST  = MM_W'(tsf_pkg::ADC_FULL - 1);
  localparam logic [AVG_W-1:0]  AVG_FULL = AVG_W'(tsf_pkg::ADC_FULL);
  localparam logic [GCNT_W-1:0] GCNT_LAST = GCNT_W'(tsf_pkg::SAMPLE_GROUPS - 1);

  function automatic logic [MM_W-1:0] min3(logic [MM_W-1:0] a, logic [MM_W-1:0] b,
                                           logic [MM_W-1:0] c);
    logic [MM_W-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic logic [MM_W-1:0] max3(logic [MM_W-1:0] a, logic [MM_W-1:0] b,
                                           logic [MM_W-1:0] c);
    logic [MM_W-1:0] m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  // Configuration registers
  logic [tsf_pkg::OFS_W-1:0] x_offset_q, y_offset_q;
  logic [tsf_pkg::SCL_W-1:0] x_scale_q, y_scale_q;
  logic [tsf_pkg::LIM_W-1:0] level_limit_q, x_spread_limit_q, y_spread_limit_q;

  // Accumulators
  logic [SUM_W-1:0]  x_sum_q, x_sum_d, y_sum_q, y_sum_d;
  logic [MM_W-1:0]   x_low_q, x_low_d, x_high_q, x_high_d;
  logic [MM_W-1:0]   y_low_q, y_low_d, y_high_q, y_high_d;
  logic [GCNT_W-1:0] gcnt_q, gcnt_d;

  // Frame results
  logic [AVG_W-1:0] x_avg_q, y_avg_q;
  logic             touch_q;
  logic [POS_W-1:0] x_pos_q;

  // Output register
  logic               out_valid_q, out_valid_d;
  tsf_pkg::out_item_t out_q;

  logic [MM_W-1:0]   xf, yf, xr, yr;
  logic [MM_W-1:0]   x_spread, y_spread;
  logic [AVG_W-1:0]  y_inv;
  logic [WIDE_W-1:0] diff_x, diff_y;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;
  logic [AVG_W-1:0]  quot;
  logic [POS_W-1:0]  scaled;
  logic              touch;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q       <= tsf_pkg::X_OFFSET_RST;
      y_offset_q       <= tsf_pkg::Y_OFFSET_RST;
      x_scale_q        <= tsf_pkg::X_SCALE_RST;
      y_scale_q        <= tsf_pkg::Y_SCALE_RST;
      level_limit_q    <= tsf_pkg::LEVEL_LIMIT_RST;
      x_spread_limit_q <= tsf_pkg::X_SPREAD_LIMIT_RST;
      y_spread_limit_q <= tsf_pkg::Y_SPREAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsf_pkg::CFG_X_OFFSET:       x_offset_q       <= cfg_wdata_i[tsf_pkg::OFS_W-1:0];
        tsf_pkg::CFG_Y_OFFSET:       y_offset_q       <= cfg_wdata_i[tsf_pkg::OFS_W-1:0];
        tsf_pkg::CFG_X_SCALE:        x_scale_q        <= cfg_wdata_i[tsf_pkg::SCL_W-1:0];
        tsf_pkg::CFG_Y_SCALE:        y_scale_q        <= cfg_wdata_i[tsf_pkg::SCL_W-1:0];
        tsf_pkg::CFG_LEVEL_LIMIT:    level_limit_q    <= cfg_wdata_i[tsf_pkg::LIM_W-1:0];
        tsf_pkg::CFG_X_SPREAD_LIMIT: x_spread_limit_q <= cfg_wdata_i[tsf_pkg::LIM_W-1:0];
        tsf_pkg::CFG_Y_SPREAD_LIMIT: y_spread_limit_q <= cfg_wdata_i[tsf_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Invert reversed readings against full scale
  assign xf = {1'b0, in_data_i.x_forward};
  assign yf = {1'b0, in_data_i.y_forward};
  assign xr = MM_FULL - {1'b0, in_data_i.x_reverse};
  assign yr = MM_FULL - {1'b0, in_data_i.y_reverse};

  // Accumulate one group, or clear after the frame result is taken
  always_comb begin
    x_sum_d  = x_sum_q;
    y_sum_d  = y_sum_q;
    x_low_d  = x_low_q;
    x_high_d = x_high_q;
    y_low_d  = y_low_q;
    y_high_d = y_high_q;
    gcnt_d   = gcnt_q;
    if (cmd_i.clear) begin
      x_sum_d  = '0;
      y_sum_d  = '0;
      x_low_d  = LOW_RST;
      x_high_d = '0;
      y_low_d  = LOW_RST;
      y_high_d = '0;
      gcnt_d   = '0;
    end else if (cmd_i.acc) begin
      x_sum_d  = x_sum_q + SUM_W'(xf) + SUM_W'(xr);
      y_sum_d  = y_sum_q + SUM_W'(yf) + SUM_W'(yr);
      x_low_d  = min3(x_low_q, xf, xr);
      x_high_d = max3(x_high_q, xf, xr);
      y_low_d  = min3(y_low_q, yf, yr);
      y_high_d = max3(y_high_q, yf, yr);
      gcnt_d   = (gcnt_q == GCNT_LAST) ? '0 : gcnt_q + GCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_sum_q  <= '0;
      y_sum_q  <= '0;
      x_low_q  <= LOW_RST;
      x_high_q <= '0;
      y_low_q  <= LOW_RST;
      y_high_q <= '0;
      gcnt_q   <= '0;
    end else begin
      x_sum_q  <= x_sum_d;
      y_sum_q  <= y_sum_d;
      x_low_q  <= x_low_d;
      x_high_q <= x_high_d;
      y_low_q  <= y_low_d;
      y_high_q <= y_high_d;
      gcnt_q   <= gcnt_d;
    end
  end

  // Spreads, touch decision and offset differences
  assign x_spread = (x_high_q >= x_low_q) ? x_high_q - x_low_q : '0;
  assign y_spread = (y_high_q >= y_low_q) ? y_high_q - y_low_q : '0;
  assign touch = (WIDE_W'(x_avg_q) < WIDE_W'(level_limit_q)) &&
                 (WIDE_W'(y_avg_q) < WIDE_W'(level_limit_q)) &&
                 (WIDE_W'(x_spread) < WIDE_W'(x_spread_limit_q)) &&
                 (WIDE_W'(y_spread) < WIDE_W'(y_spread_limit_q));

  assign y_inv  = AVG_FULL - y_avg_q;
  assign diff_x = (WIDE_W'(x_avg_q) <= WIDE_W'(x_offset_q)) ? '0 :
                  WIDE_W'(x_avg_q) - WIDE_W'(x_offset_q);
  assign diff_y = (WIDE_W'(y_inv) <= WIDE_W'(y_offset_q)) ? '0 :
                  WIDE_W'(y_inv) - WIDE_W'(y_offset_q);

  // Select operands of the shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      tsf_pkg::OP_DIV_X: begin
        mul_a = MA_W'(x_sum_q);
        mul_b = MB_W'(tsf_pkg::RECIP);
      end
      tsf_pkg::OP_DIV_Y: begin
        mul_a = MA_W'(y_sum_q);
        mul_b = MB_W'(tsf_pkg::RECIP);
      end
      tsf_pkg::OP_SCL_X: begin
        mul_a = MA_W'(diff_x);
        mul_b = MB_W'(x_scale_q);
      end
      tsf_pkg::OP_SCL_Y: begin
        mul_a = MA_W'(diff_y);
        mul_b = MB_W'(y_scale_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Quotient for divides; drop fraction bits and saturate for scalings
  assign quot   = prod[tsf_pkg::DIV_SHIFT +: AVG_W];
  assign scaled = (|prod[PROD_W-1:FRAC+POS_W]) ? '1 : prod[FRAC +: POS_W];

  // Capture averages, touch flag and X coordinate
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tsf_pkg::OP_DIV_X) begin
      x_avg_q <= quot;
    end
    if (cmd_i.op == tsf_pkg::OP_DIV_Y) begin
      y_avg_q <= quot;
    end
    if (cmd_i.op == tsf_pkg::OP_SCL_X) begin
      touch_q <= touch;
      x_pos_q <= touch ? scaled : '0;
    end
  end

  // Output register: load the frame result, drop it after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.x_pos   <= x_pos_q;
      out_q.y_pos   <= touch_q ? scaled : '0;
      out_q.touched <= touch_q;
    end
  end

  assign status_o.last_group = (gcnt_q == GCNT_LAST);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;

endmodule

`default_nettype wire

>>> sv/touch_sample_filter_top.sv
// Touch sample filter: averaging and validation of resistive panel readings, top level
//
// Takes one sample group per transfer on in_ch (X and Y readings with forward and reversed
// plate polarity) at one group per cycle. After every tsf_pkg::SAMPLE_GROUPS groups it
// averages both axes, checks level and spread limits and delivers one result on out_ch:
// scaled X and Y coordinates and a touched flag, both coordinates 0 without a touch.
// The frame result is worked out on one shared multiplier in four steps (X divide,
// Y divide, X scale, Y scale), during which in_ch is not ready; the last step waits
// further while the output register still holds an untaken result. Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i by the user, who must write it
// only while no frame is in progress; the block itself does not enforce this.
`default_nettype none

module touch_sample_filter_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [tsf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [tsf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  tsf_in_if.sink                          in_ch,
  tsf_out_if.source                       out_ch
);

  tsf_pkg::ctrl_cmd_t    cmd;
  tsf_pkg::ctrl_status_t status;
  logic                  in_ready;
  logic                  out_valid;
  tsf_pkg::out_item_t    out_data;

  // Sequence the frame
  tsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Accumulate, divide, scale and hold the result
  tsf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_ch.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_data)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

`default_nettype wire

>>> sv/tsf_checker.sv
// Port-level checks for the touch sample filter and their bind
`default_nettype none

`include "touch_sample_filter_top_defines.svh"

module tsf_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_i,
  input wire                      out_valid_i,
  input wire                      out_ready_i,
  input wire [tsf_pkg::POS_W-1:0] x_pos_i,
  input wire [tsf_pkg::POS_W-1:0] y_pos_i,
  input wire                      touched_i
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A result without a touch carries zero coordinates
  `TSF_ASSERT_IMP(a_no_touch_zero, out_valid_i && !touched_i, (x_pos_i == '0) && (y_pos_i == '0))

  // A stalled result holds
  `TSF_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable({x_pos_i, y_pos_i, touched_i}))

  // A new result follows a cycle in which input was held off
  `TSF_ASSERT_IMP(a_result_after_stall, $rose(out_valid_i), !$past(in_ready_i))

  // A group transfer never lands in the cycle a fresh result is loaded
  `TSF_ASSERT_NXT(a_no_result_on_xfer, in_xfer && !out_valid_i, !out_valid_i)

endmodule

bind touch_sample_filter_top tsf_checker u_tsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .x_pos_i     (out_ch.data.x_pos),
  .y_pos_i     (out_ch.data.y_pos),
  .touched_i   (out_ch.data.touched)
);

`default_nettype wire
